// ===== rtl/core/epf_pkg.sv =====
// shared codes and field widths for the euler path finder
`timescale 1ns / 1ps
`default_nettype none

package epf_pkg;

    // width of a node field on either stream
    localparam int FIELD_W = 4;

    // operation codes carried in the input tuser
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // result status codes carried in the output tuser
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_PATH = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/euler_path_finder.sv =====
// euler path finder: edge loader, parity scan, stack walk and path emitter
`timescale 1ns / 1ps
`default_nettype none

// Loads undirected edges into an adjacency bit matrix and, on a find
// transaction, emits an Eulerian path by Hierholzer's walk, lowest neighbor
// first. The matrix sits in a simple dual-port synchronous memory (one read,
// one write per cycle) with a valid bit per row, so a row never written reads
// as zero and the whole graph clears through the valid bits at the end of every find. The
// walk stack and the path share a second memory. An add transaction is
// accepted, then does a read-modify-write of each endpoint's row. A find
// is accepted, scans the degree parities of all MAX_NODES nodes, walks
// edges and pops vertices into the path, then emits the path vertices,
// holding each one while the output is not taken.
// The output register lets the next transaction enter while the final
// result still waits. Adds beyond MAX_EDGES since the last find, or with an
// endpoint of MAX_NODES or more, are dropped; a wrong odd-node count gives
// one result with status set.
module euler_path_finder #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input stream
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // node_u [3:0], node_v [7:4]
    input  wire logic       i_s_axis_tuser,   // operation [0]
    // result stream
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic      [7:0] o_m_axis_tdata,   // vertex [3:0], zero [7:4]
    output logic            o_m_axis_tuser,   // status [0]
    output logic            o_m_axis_tlast
);

    localparam int FW    = epf_pkg::FIELD_W;
    localparam int NW    = $clog2(MAX_NODES);
    localparam int IW    = (NW > FW) ? NW : FW;
    localparam int DEPTH = MAX_EDGES + 1;
    localparam int DW    = $clog2(DEPTH + 1);
    localparam int LCW   = $clog2(MAX_EDGES + 1);
    localparam int WAW   = $clog2(2 * DEPTH);

    typedef logic [MAX_NODES-1:0] t_row;
    typedef logic [NW-1:0]        t_node;

    localparam t_row ROW_ONE = t_row'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_U,
        S_ADD_V,
        S_SCAN,
        S_FAIL,
        S_W_READ,
        S_W_EVAL,
        S_W_CLR,
        S_W_POP,
        S_E_READ,
        S_E_LOAD
    } t_state;

    // one-hot row mask of a node
    function automatic t_row f_bit(input t_node idx);
        return ROW_ONE << idx;
    endfunction

    // lowest set bit of a row
    function automatic t_node f_lowest(input t_row row);
        t_node idx;
        idx = '0;
        for (int j = MAX_NODES - 1; j >= 0; j--) begin
            if (row[j]) begin
                idx = NW'(j);
            end
        end
        return idx;
    endfunction

    // state and registered outputs
    t_state            r_state, n_state;
    t_node             r_u, n_u;
    t_node             r_v, n_v;
    logic [LCW-1:0]    r_lc, n_lc;
    t_row              r_parity, n_parity;
    t_row              r_valid, n_valid;
    t_node             r_scan, n_scan;
    logic [1:0]        r_odd, n_odd;
    t_node             r_start, n_start;
    t_node             r_top, n_top;
    t_node             r_w, n_w;
    t_node             r_prev, n_prev;
    logic [DW-1:0]     r_depth, n_depth;
    logic [DW-1:0]     r_plen, n_plen;
    logic [DW-1:0]     r_eidx, n_eidx;
    logic              r_out_valid, n_out_valid;
    logic [FW-1:0]     r_out_vertex, n_out_vertex;
    logic              r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    // adjacency memory ports
    t_row              adj_mem [MAX_NODES];
    logic              adj_we, adj_re;
    t_node             adj_waddr, adj_raddr;
    t_row              adj_wdata;
    t_row              r_adj_q;
    logic              r_adj_qv;

    // walk memory ports: stack in the lower half, path in the upper half
    t_node             wk_mem [2*DEPTH];
    logic              wk_we, wk_re;
    logic [WAW-1:0]    wk_waddr, wk_raddr;
    t_node             wk_wdata;
    t_node             r_wk_q;

    // input field decode
    logic [FW-1:0]     in_u4, in_v4;
    logic [IW-1:0]     in_u_ext, in_v_ext;
    t_node             in_u, in_v;
    logic              in_ok;

    // working values
    t_row              adj_row;
    t_node             nb;
    logic              out_free;
    logic [IW-1:0]     wk_q_ext;
    logic [WAW-1:0]    path_base;

    assign in_u4    = i_s_axis_tdata[3:0];
    assign in_v4    = i_s_axis_tdata[7:4];
    assign in_u_ext = IW'(in_u4);
    assign in_v_ext = IW'(in_v4);
    assign in_u     = in_u_ext[NW-1:0];
    assign in_v     = in_v_ext[NW-1:0];
    assign in_ok    = (32'(in_u4) < MAX_NODES) && (32'(in_v4) < MAX_NODES)
                      && (32'(r_lc) < MAX_EDGES);

    assign adj_row   = r_adj_qv ? r_adj_q : '0;
    assign nb        = f_lowest(adj_row);
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign wk_q_ext  = IW'(r_wk_q);
    assign path_base = WAW'(DEPTH);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_vertex};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // next-state and memory control
    always_comb begin
        n_state      = r_state;
        n_u          = r_u;
        n_v          = r_v;
        n_lc         = r_lc;
        n_parity     = r_parity;
        n_valid      = r_valid;
        n_scan       = r_scan;
        n_odd        = r_odd;
        n_start      = r_start;
        n_top        = r_top;
        n_w          = r_w;
        n_prev       = r_prev;
        n_depth      = r_depth;
        n_plen       = r_plen;
        n_eidx       = r_eidx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_vertex = r_out_vertex;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        adj_we       = 1'b0;
        adj_waddr    = r_top;
        adj_wdata    = adj_row;
        adj_re       = 1'b0;
        adj_raddr    = r_top;
        wk_we        = 1'b0;
        wk_waddr     = WAW'(r_depth);
        wk_wdata     = r_top;
        wk_re        = 1'b0;
        wk_raddr     = path_base + WAW'(r_eidx);

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser == epf_pkg::OP_ADD) begin
                        if (in_ok) begin
                            n_u       = in_u;
                            n_v       = in_v;
                            n_parity  = r_parity ^ f_bit(in_u) ^ f_bit(in_v);
                            n_lc      = r_lc + LCW'(1);
                            adj_re    = 1'b1;
                            adj_raddr = in_u;
                            n_state   = S_ADD_U;
                        end
                    end else begin
                        n_scan  = '0;
                        n_odd   = '0;
                        n_start = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            // set bit v in row u, then fetch row v
            S_ADD_U: begin
                adj_we    = 1'b1;
                adj_waddr = r_u;
                adj_wdata = adj_row | f_bit(r_v);
                adj_re    = 1'b1;
                adj_raddr = r_v;
                n_state   = S_ADD_V;
            end

            S_ADD_V: begin
                adj_we    = 1'b1;
                adj_waddr = r_v;
                adj_wdata = adj_row | f_bit(r_u);
                n_state   = S_IDLE;
            end

            // count odd nodes, saturating, and keep the highest one
            S_SCAN: begin
                if (r_parity[r_scan]) begin
                    n_start = r_scan;
                    if (r_odd != 2'd3) begin
                        n_odd = r_odd + 2'd1;
                    end
                end
                n_scan = r_scan + NW'(1);
                if (r_scan == NW'(MAX_NODES - 1)) begin
                    if (n_odd == 2'd1 || n_odd == 2'd3) begin
                        n_state = S_FAIL;
                    end else begin
                        wk_we    = 1'b1;
                        wk_waddr = '0;
                        wk_wdata = n_start;
                        n_top    = n_start;
                        n_depth  = DW'(1);
                        n_plen   = '0;
                        n_state  = S_W_READ;
                    end
                end
            end

            S_FAIL: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = '0;
                    n_out_status = epf_pkg::STATUS_NO_PATH;
                    n_out_last   = 1'b1;
                    n_parity     = '0;
                    n_valid      = '0;
                    n_lc         = '0;
                    n_state      = S_IDLE;
                end
            end

            S_W_READ: begin
                adj_re    = 1'b1;
                adj_raddr = r_top;
                n_state   = S_W_EVAL;
            end

            // take the lowest neighbor or pop the top into the path
            S_W_EVAL: begin
                if (adj_row != '0) begin
                    adj_we    = 1'b1;
                    adj_waddr = r_top;
                    adj_wdata = adj_row & ~f_bit(nb);
                    adj_re    = 1'b1;
                    adj_raddr = nb;
                    n_w       = nb;
                    n_prev    = r_top;
                    if (32'(r_depth) < DEPTH) begin
                        wk_we    = 1'b1;
                        wk_waddr = WAW'(r_depth);
                        wk_wdata = nb;
                        n_depth  = r_depth + DW'(1);
                        n_top    = nb;
                    end
                    n_state = S_W_CLR;
                end else begin
                    if (32'(r_plen) < DEPTH) begin
                        wk_we    = 1'b1;
                        wk_waddr = path_base + WAW'(r_plen);
                        wk_wdata = r_top;
                        n_plen   = r_plen + DW'(1);
                    end
                    n_depth = r_depth - DW'(1);
                    if (r_depth == DW'(1)) begin
                        n_eidx  = n_plen - DW'(1);
                        n_state = S_E_READ;
                    end else begin
                        wk_re    = 1'b1;
                        wk_raddr = WAW'(r_depth) - WAW'(2);
                        n_state  = S_W_POP;
                    end
                end
            end

            // remove the reverse half of the edge
            S_W_CLR: begin
                adj_we    = 1'b1;
                adj_waddr = r_w;
                adj_wdata = adj_row & ~f_bit(r_prev);
                n_state   = S_W_READ;
            end

            S_W_POP: begin
                n_top   = r_wk_q;
                n_state = S_W_READ;
            end

            // emit the path in reverse pop order
            S_E_READ: begin
                wk_re    = 1'b1;
                wk_raddr = path_base + WAW'(r_eidx);
                n_state  = S_E_LOAD;
            end

            S_E_LOAD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = wk_q_ext[FW-1:0];
                    n_out_status = epf_pkg::STATUS_OK;
                    n_out_last   = (r_eidx == '0);
                    if (r_eidx == '0) begin
                        n_parity = '0;
                        n_valid  = '0;
                        n_lc     = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_eidx  = r_eidx - DW'(1);
                        n_state = S_E_READ;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a written row becomes valid unless the graph is being cleared
        if (adj_we && (n_valid != '0 || r_valid == '0)) begin
            n_valid[adj_waddr] = 1'b1;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lc        <= '0;
            r_parity    <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lc        <= n_lc;
            r_parity    <= n_parity;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_u          <= n_u;
        r_v          <= n_v;
        r_scan       <= n_scan;
        r_odd        <= n_odd;
        r_start      <= n_start;
        r_top        <= n_top;
        r_w          <= n_w;
        r_prev       <= n_prev;
        r_depth      <= n_depth;
        r_plen       <= n_plen;
        r_eidx       <= n_eidx;
        r_out_vertex <= n_out_vertex;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // adjacency memory, registered read with row valid
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            r_adj_q  <= adj_mem[adj_raddr];
            r_adj_qv <= r_valid[adj_raddr];
        end
    end

    // walk stack and path memory, registered read
    always_ff @(posedge i_clk) begin
        if (wk_we) begin
            wk_mem[wk_waddr] <= wk_wdata;
        end
        if (wk_re) begin
            r_wk_q <= wk_mem[wk_raddr];
        end
    end

endmodule

`default_nettype wire
